// ===== hw/rtl/eofw_pkg.sv =====
// ----------------------------------------------------------------------------
// eofw_pkg: shared types and constants of the edge order frontier width unit
// Request/result payloads, table entry layout and controller handshake types.
// ----------------------------------------------------------------------------
package eofw_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int DEGREE_BITS  = 16;
	localparam int VTX_AW       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 11;
	localparam int WID_W        = 12;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_PROCESS = 2'd1;
	localparam logic [1:0] OP_FINISH  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [9:0] vertex_a;
		logic [9:0] vertex_b;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0]        bag_size;
		logic signed [WID_W-1:0] width;
		logic                    is_final;
		logic                    degree_error;
	} res_t;

	// one degree table word: frontier flag kept next to the degree
	typedef struct packed {
		logic                   flag;
		logic [DEGREE_BITS-1:0] deg;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef struct packed {
		logic accept;
		logic rd_b;
		logic cap_a;
		logic exec;
		logic wr_b;
		logic clr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic req_edge;
		logic req_fin;
		logic clr_last;
	} stat_t;

endpackage

// ===== hw/rtl/eofw_ram.sv =====
// ----------------------------------------------------------------------------
// eofw_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module eofw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/eofw_ctrl.sv =====
// ----------------------------------------------------------------------------
// eofw_ctrl: sequencing state machine
// Runs the clearing pass after reset, then steps each edge request through
// read a, read b, update and write a, write b; finish takes one step.
// ----------------------------------------------------------------------------
module eofw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  eofw_pkg::stat_t stat,
	output eofw_pkg::cmd_t  cmd
);
	import eofw_pkg::*;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_RDA  = 7'b0000100,
		S_RDB  = 7'b0001000,
		S_EXEC = 7'b0010000,
		S_WRB  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLR: begin
				if (stat.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start && stat.req_edge) state_nx = S_RDA;
				else if (start && stat.req_fin) state_nx = S_FIN;
			end
			S_RDA:  state_nx = S_RDB;
			S_RDB:  state_nx = S_EXEC;
			S_EXEC: state_nx = S_WRB;
			S_WRB:  state_nx = S_IDLE;
			S_FIN:  state_nx = S_IDLE;
			default: state_nx = S_CLR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && start;
		cmd.rd_b   = (state_q == S_RDB);
		cmd.cap_a  = (state_q == S_RDB);
		cmd.exec   = (state_q == S_EXEC);
		cmd.wr_b   = (state_q == S_WRB);
		cmd.clr    = (state_q == S_CLR);
		cmd.finish = (state_q == S_FIN);
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/eofw_dpath.sv =====
// ----------------------------------------------------------------------------
// eofw_dpath: degree table, frontier count and result registers
// Holds the request, reads both table words, applies the load or process
// update and writes the words back; keeps the running counts and result.
// ----------------------------------------------------------------------------
module eofw_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  eofw_pkg::req_t  req,
	input  eofw_pkg::cmd_t  cmd,
	output eofw_pkg::stat_t stat,
	output logic            done,
	output eofw_pkg::res_t  result
);
	import eofw_pkg::*;

	typedef struct packed {
		logic                   err;
		logic [DEGREE_BITS-1:0] deg;
	} step_t;

	localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};

	function automatic logic [VTX_AW-1:0] vtx_addr(input logic [9:0] v);
		logic [31:0] t;
		t = 32'(v);
		return VTX_AW'(t % MAX_VERTICES);
	endfunction

	// saturate on increment, hold at zero on decrement
	function automatic step_t deg_step(input logic [DEGREE_BITS-1:0] d, input logic up);
		step_t s;
		s.err = 1'b0;
		s.deg = d;
		if (up) begin
			if (d == DEG_MAX) s.err = 1'b1;
			else s.deg = d + DEGREE_BITS'(1);
		end else begin
			if (d == '0) s.err = 1'b1;
			else s.deg = d - DEGREE_BITS'(1);
		end
		return s;
	endfunction

	logic [1:0]        op_q;
	logic [VTX_AW-1:0] a_q, b_q, clr_idx_q;
	ent_t              ent_a_q, nb_q;
	logic [CNT_W-1:0]  fc_q, largest_q;
	logic              err_q;
	logic              done_q;
	res_t              result_q;

	logic             ram_we;
	logic [VTX_AW-1:0] ram_waddr, ram_raddr;
	ent_t             ram_wdata, ram_rdata;

	logic             same, is_load;
	ent_t             ea, eb, na, nb;
	step_t            a1, a2, b1;
	logic             up_a, dn_a, up_b, dn_b;
	logic [CNT_W-1:0] bag, fc_nx, largest_nx;
	logic             err_nx;

	assign stat.req_edge = (req.op == OP_LOAD) || (req.op == OP_PROCESS);
	assign stat.req_fin  = (req.op == OP_FINISH);
	assign stat.clr_last = (clr_idx_q == VTX_AW'(MAX_VERTICES - 1));

	// ---- update of the two table words ----
	always_comb begin
		same    = (a_q == b_q);
		is_load = (op_q == OP_LOAD);
		ea      = ent_a_q;
		eb      = same ? ent_a_q : ram_rdata;

		// self-loop: both steps land on the same word
		a1 = deg_step(ea.deg, is_load);
		a2 = deg_step(a1.deg, is_load);
		b1 = deg_step(eb.deg, is_load);

		na.deg = same ? a2.deg : a1.deg;
		na.flag = is_load ? ea.flag : (na.deg != '0);
		nb.deg = same ? na.deg : b1.deg;
		nb.flag = is_load ? eb.flag : (nb.deg != '0);

		err_nx = err_q | a1.err | (same ? a2.err : b1.err);

		up_a = na.flag & ~ea.flag;
		dn_a = ~na.flag & ea.flag;
		up_b = ~same & nb.flag & ~eb.flag;
		dn_b = ~same & ~nb.flag & eb.flag;

		bag   = fc_q + CNT_W'(!ea.flag) + CNT_W'(!eb.flag);
		fc_nx = fc_q + CNT_W'(up_a) + CNT_W'(up_b) - CNT_W'(dn_a) - CNT_W'(dn_b);
		largest_nx = (bag > largest_q) ? bag : largest_q;
	end

	// ---- table RAM ----
	always_comb begin
		ram_we    = cmd.clr | cmd.exec | cmd.wr_b;
		ram_raddr = cmd.rd_b ? b_q : a_q;
		if (cmd.clr) begin
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else if (cmd.exec) begin
			ram_waddr = a_q;
			ram_wdata = na;
		end else begin
			ram_waddr = b_q;
			ram_wdata = nb_q;
		end
	end

	eofw_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_VERTICES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= req.op;
			a_q  <= vtx_addr(req.vertex_a);
			b_q  <= vtx_addr(req.vertex_b);
		end
		if (cmd.cap_a) ent_a_q <= ram_rdata;
		if (cmd.exec) nb_q <= nb;
		if (cmd.exec) begin
			result_q.bag_size     <= bag;
			result_q.width        <= $signed(WID_W'({1'b0, largest_nx}) - WID_W'(1));
			result_q.is_final     <= 1'b0;
			result_q.degree_error <= err_nx;
		end else if (cmd.finish) begin
			result_q.bag_size     <= '0;
			result_q.width        <= $signed(WID_W'({1'b0, largest_q}) - WID_W'(1));
			result_q.is_final     <= 1'b1;
			result_q.degree_error <= err_q;
		end
	end

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			fc_q      <= '0;
			largest_q <= '0;
			err_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.clr) clr_idx_q <= clr_idx_q + VTX_AW'(1);
			done_q <= (cmd.exec && (op_q == OP_PROCESS)) || cmd.finish;
			if (cmd.exec) begin
				err_q <= err_nx;
				if (!is_load) begin
					fc_q      <= fc_nx;
					largest_q <= largest_nx;
				end
			end else if (cmd.finish) begin
				largest_q <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// ---- assertions ----
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.finish || (cmd.exec && (op_q == OP_PROCESS))))
		else $error("result strobe without a process or finish step");

	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.is_final) |-> (largest_q == '0))
		else $error("largest bag not cleared by finish");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("degree error flag dropped");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !ram_we)
		else $error("table write while taking a request");

endmodule

// ===== hw/rtl/edge_order_frontier_width_unit.sv =====
// ----------------------------------------------------------------------------
// edge_order_frontier_width_unit: edge order frontier width meter
// A request is taken when start is high and busy is low. After reset the
// unit clears its 1024-entry degree table, one entry a cycle, and holds busy
// high until it is clear. A load or process request then runs a take, two
// reads and two writes (the degree table has one read and one write port);
// a finish runs a take and a finish step, and an unused op code is taken
// without leaving idle. Process and finish each give one result, shown for
// exactly one cycle with done high after the update or finish step; the
// receiver cannot stall it. Loads give none.
// ----------------------------------------------------------------------------
module edge_order_frontier_width_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  eofw_pkg::req_t req,
	output logic           done,
	output eofw_pkg::res_t result
);
	import eofw_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	eofw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	eofw_dpath u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.done  (done),
		.result(result)
	);

endmodule
